FILE: rtl/fdcf_pkg.sv
// ----------------------------------------------------------------------------
// fdcf_pkg
// shared types, widths and constants of the fractional delay line with
// cubic interpolation and feedback
// ----------------------------------------------------------------------------
package fdcf_pkg;

  localparam int DEPTH      = 4096;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int SAMPLE_W   = 24;
  localparam int DELAY_W    = 24;
  localparam int GAIN_W     = 16;
  localparam int FRAC_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 52;
  localparam int SUM_W  = 30;
  localparam int POLY_W = 30;
  localparam int NREG_W = 30;
  localparam int WGT_W  = 27;
  localparam int F2_W   = 2 * FRAC_W;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = CFG_IDX_W'(1);

  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(8388608);

  localparam int FB_SHIFT   = 15;
  localparam int DIV_SHIFT  = 13;
  localparam int RCP_SHIFT  = 31;
  localparam int OUT_SHIFT  = 24;

  // weight polynomial constants in units of 2^-24
  localparam logic signed [POLY_W-1:0] C_ONE = POLY_W'(1 << 24);
  localparam logic signed [POLY_W-1:0] C_TWO = POLY_W'(2 << 24);
  localparam logic signed [POLY_W-1:0] C_THR = POLY_W'(3 << 24);
  localparam logic signed [POLY_W-1:0] C_SIX = POLY_W'(6 << 24);

  // round to nearest over 6*2^12, split as /2^13 then /3 on an offset value
  localparam logic signed [PROD_W-1:0] DIV_OFS =
    PROD_W'(12288) + (PROD_W'(3) << 40);
  localparam logic signed [MUL_W-1:0] RECIP_THIRD = MUL_W'(32'h2AAA_AAAB);
  localparam logic signed [MUL_W-2:0] Q_OFS = (MUL_W-1)'(1 << 27);

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(1 << (SAMPLE_W - 1)));

  typedef struct packed {
    logic prod_en;
    logic acc_clr;
    logic acc_add;
  } mac_ctrl_t;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_FBK  = 11'b000_0000_0010,
    ST_WRT  = 11'b000_0000_0100,
    ST_SQR  = 11'b000_0000_1000,
    ST_POLY = 11'b000_0001_0000,
    ST_NUM  = 11'b000_0010_0000,
    ST_SCL  = 11'b000_0100_0000,
    ST_DIV  = 11'b000_1000_0000,
    ST_WGT  = 11'b001_0000_0000,
    ST_MAC  = 11'b010_0000_0000,
    ST_RES  = 11'b100_0000_0000
  } state_t;

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SAMPLE_W-1:0] r;
    priority if (v > SAT_HI) begin
      r = SAMPLE_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = SAMPLE_W'(SAT_LO);
    end else begin
      r = SAMPLE_W'(v);
    end
    return r;
  endfunction

endpackage

FILE: rtl/fdcf_mac.sv
// ----------------------------------------------------------------------------
// fdcf_mac
// shared signed multiplier with registered product and accumulator
// ----------------------------------------------------------------------------
module fdcf_mac (
  input  logic                                  clk,
  input  fdcf_pkg::mac_ctrl_t                   ctrl,
  input  logic signed [fdcf_pkg::MUL_W-1:0]     mul_a,
  input  logic signed [fdcf_pkg::MUL_W-1:0]     mul_b,
  output logic signed [fdcf_pkg::PROD_W-1:0]    prod,
  output logic signed [fdcf_pkg::ACC_W-1:0]     acc
);

  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      prod <= mul_a * mul_b;
    end
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (ctrl.acc_add) begin
      acc <= acc + fdcf_pkg::ACC_W'(prod);
    end
  end

endmodule

FILE: rtl/fractional_delay_cubic_feedback_top.sv
// ----------------------------------------------------------------------------
// fractional_delay_cubic_feedback_top
// a new item is accepted only when idle, once the previous result is in the
//   output register; the single shared multiplier serves the feedback,
//   the fraction square, the four weights and the four taps in turn
// reset: control and config registers reset; delay memory entries not yet
//   written since reset read as zero through a fill count, no clearing pass
// ----------------------------------------------------------------------------
module fractional_delay_cubic_feedback_top (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [fdcf_pkg::SAMPLE_W-1:0]      sample_in,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [fdcf_pkg::SAMPLE_W-1:0]      sample_out,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [fdcf_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [fdcf_pkg::CFG_DATA_W-1:0]           cfg_data
);

  localparam int AW = fdcf_pkg::ADDR_W;
  localparam int SW = fdcf_pkg::SAMPLE_W;
  localparam int PW = fdcf_pkg::POLY_W;
  localparam int FW = fdcf_pkg::FRAC_W;
  localparam int MW = fdcf_pkg::MUL_W;
  localparam int TW = fdcf_pkg::SUM_W;
  localparam logic [AW:0] FILL_FULL = (AW + 1)'(fdcf_pkg::DEPTH);

  fdcf_pkg::state_t state;
  logic [2:0]       k;

  logic [fdcf_pkg::DELAY_W-1:0]        delay_samples;
  logic signed [fdcf_pkg::GAIN_W-1:0]  feedback_gain;
  logic [AW-1:0]                       wp;
  logic [AW:0]                         fill;
  logic signed [SW-1:0]                last_output;

  logic signed [SW-1:0]                x;
  logic [AW-1:0]                       base;
  logic [FW-1:0]                       frac;
  logic [fdcf_pkg::F2_W-1:0]           f2;
  logic signed [PW-1:0]                poly;
  logic [fdcf_pkg::NREG_W-1:0]         nreg;
  logic signed [fdcf_pkg::WGT_W-1:0]   w [4];
  logic signed [SW-1:0]                s [4];
  logic                                tap_ok;

  logic signed [SW-1:0]                mem [fdcf_pkg::DEPTH];
  logic signed [SW-1:0]                mem_q;
  logic [AW-1:0]                       rd_addr;
  logic                                mem_we;
  logic signed [SW-1:0]                wval;

  fdcf_pkg::mac_ctrl_t                 mac_ctrl;
  logic signed [MW-1:0]                mul_a;
  logic signed [MW-1:0]                mul_b;
  logic signed [fdcf_pkg::PROD_W-1:0]  prod;
  logic signed [fdcf_pkg::ACC_W-1:0]   acc;

  logic [AW-1:0]                       ipart;
  logic [FW-1:0]                       rpart;
  logic signed [TW-1:0]                fb;
  logic signed [PW-1:0]                f2s;
  logic signed [PW-1:0]                frs;
  logic signed [PW-1:0]                fr12;
  logic signed [PW-1:0]                poly_next;
  logic signed [MW-2:0]                wq;
  logic signed [SW-1:0]                y;
  logic                                in_take;
  logic                                out_take;
  logic                                out_load;

  assign in_stall  = (state != fdcf_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign out_load  = (state == fdcf_pkg::ST_RES) && (!out_valid || !out_stall);
  assign mem_we    = (state == fdcf_pkg::ST_WRT);

  assign ipart   = AW'(delay_samples[fdcf_pkg::DELAY_W-1:FW]);
  assign rpart   = delay_samples[FW-1:0];
  assign rd_addr = AW'(base + AW'(k) - AW'(1));

  // feedback term and stored value
  assign fb   = TW'(prod >>> fdcf_pkg::FB_SHIFT);
  assign wval = fdcf_pkg::sat_sample(TW'(x) + fb);

  // weight polynomials
  assign f2s  = PW'(f2);
  assign frs  = PW'(frac);
  assign fr12 = (frs <<< 13) + (frs <<< 12);

  always_comb begin
    unique case (k[1:0])
      2'd0:    poly_next = fr12 - f2s - fdcf_pkg::C_TWO;
      2'd1:    poly_next = (f2s <<< 1) + f2s - (fr12 <<< 1) - fdcf_pkg::C_THR;
      2'd2:    poly_next = fr12 - (f2s <<< 1) - f2s + fdcf_pkg::C_SIX;
      default: poly_next = f2s - fdcf_pkg::C_ONE;
    endcase
  end

  assign wq = (MW - 1)'(prod >>> fdcf_pkg::RCP_SHIFT);
  assign y  = fdcf_pkg::sat_sample(TW'(s[1]) + TW'(acc >>> fdcf_pkg::OUT_SHIFT)
                                   + TW'(acc[fdcf_pkg::OUT_SHIFT-1]));

  // shared multiplier operand select
  always_comb begin
    mac_ctrl = '0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      fdcf_pkg::ST_FBK: begin
        mac_ctrl.prod_en = 1'b1;
        mul_a = MW'(last_output);
        mul_b = MW'(feedback_gain);
      end
      fdcf_pkg::ST_WRT: begin
        mac_ctrl.prod_en = 1'b1;
        mul_a = MW'(frac);
        mul_b = MW'(frac);
      end
      fdcf_pkg::ST_NUM: begin
        mac_ctrl.prod_en = 1'b1;
        mul_a = MW'(frac);
        mul_b = MW'(poly);
      end
      fdcf_pkg::ST_DIV: begin
        mac_ctrl.prod_en = 1'b1;
        mul_a = MW'(nreg);
        mul_b = fdcf_pkg::RECIP_THIRD;
      end
      fdcf_pkg::ST_MAC: begin
        mac_ctrl.prod_en = !k[2];
        mac_ctrl.acc_clr = (k == 3'd0);
        mac_ctrl.acc_add = (k != 3'd0);
        mul_a = MW'(w[k[1:0]]);
        mul_b = MW'(s[k[1:0]]);
      end
      default: begin
      end
    endcase
  end

  fdcf_mac u_mac (
    .clk   (clk),
    .ctrl  (mac_ctrl),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod),
    .acc   (acc)
  );

  // delay memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= wval;
    end
    mem_q <= mem[rd_addr];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= fdcf_pkg::ST_IDLE;
      k             <= '0;
      wp            <= '0;
      fill          <= '0;
      last_output   <= '0;
      out_valid     <= 1'b0;
      delay_samples <= fdcf_pkg::DELAY_RESET;
      feedback_gain <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          fdcf_pkg::REG_DELAY: delay_samples <= cfg_data;
          fdcf_pkg::REG_GAIN:  feedback_gain <= cfg_data[fdcf_pkg::GAIN_W-1:0];
          default: begin
          end
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        fdcf_pkg::ST_IDLE: begin
          if (in_take) begin
            state <= fdcf_pkg::ST_FBK;
          end
        end
        fdcf_pkg::ST_FBK: state <= fdcf_pkg::ST_WRT;
        fdcf_pkg::ST_WRT: begin
          wp <= AW'(wp + AW'(1));
          if (fill != FILL_FULL) begin
            fill <= fill + (AW + 1)'(1);
          end
          k     <= '0;
          state <= fdcf_pkg::ST_SQR;
        end
        fdcf_pkg::ST_SQR:  state <= fdcf_pkg::ST_POLY;
        fdcf_pkg::ST_POLY: state <= fdcf_pkg::ST_NUM;
        fdcf_pkg::ST_NUM:  state <= fdcf_pkg::ST_SCL;
        fdcf_pkg::ST_SCL:  state <= fdcf_pkg::ST_DIV;
        fdcf_pkg::ST_DIV:  state <= fdcf_pkg::ST_WGT;
        fdcf_pkg::ST_WGT: begin
          if (k == 3'd3) begin
            k     <= '0;
            state <= fdcf_pkg::ST_MAC;
          end else begin
            k     <= k + 3'd1;
            state <= fdcf_pkg::ST_POLY;
          end
        end
        fdcf_pkg::ST_MAC: begin
          if (k[2]) begin
            state <= fdcf_pkg::ST_RES;
          end else begin
            k <= k + 3'd1;
          end
        end
        fdcf_pkg::ST_RES: begin
          if (out_load) begin
            last_output <= y;
            state       <= fdcf_pkg::ST_IDLE;
          end
        end
        default: state <= fdcf_pkg::ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      x    <= sample_in;
      base <= AW'(wp - ipart - AW'(rpart != '0));
      frac <= '0 - rpart;
    end
    if (state == fdcf_pkg::ST_SQR) begin
      f2 <= prod[fdcf_pkg::F2_W-1:0];
    end
    if (state == fdcf_pkg::ST_POLY) begin
      poly   <= poly_next;
      tap_ok <= (fill == FILL_FULL) || ({1'b0, rd_addr} < fill);
    end
    if (state == fdcf_pkg::ST_NUM) begin
      s[k[1:0]] <= tap_ok ? mem_q : '0;
    end
    if (state == fdcf_pkg::ST_SCL) begin
      nreg <= fdcf_pkg::NREG_W'((prod + fdcf_pkg::DIV_OFS) >>> fdcf_pkg::DIV_SHIFT);
    end
    if (state == fdcf_pkg::ST_WGT) begin
      w[k[1:0]] <= fdcf_pkg::WGT_W'(wq - fdcf_pkg::Q_OFS);
    end
    if (out_load) begin
      sample_out <= y;
    end
  end

endmodule
